// ----- design/nmea_sentence_classifier_defines.svh -----
// Assertion macros shared by the sentence classifier RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef NMEA_SENTENCE_CLASSIFIER_DEFINES_SVH
`define NMEA_SENTENCE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define NSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define NSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NSC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define NSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/nsc_pkg.sv -----
// Shared types, codes and lookup functions for the NMEA sentence classifier.
// No dependencies.
package nsc_pkg;

   localparam int NSC_MAX_LEN = 128;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_P      = 8'h50;

   localparam logic [2:0] KIND_GGA = 3'd0;
   localparam logic [2:0] KIND_GSA = 3'd1;
   localparam logic [2:0] KIND_GSV = 3'd2;
   localparam logic [2:0] KIND_GLL = 3'd3;
   localparam logic [2:0] KIND_RMC = 3'd4;
   localparam logic [2:0] KIND_VTG = 3'd5;
   localparam logic [2:0] KIND_ZDA = 3'd6;

   localparam logic [1:0] VERDICT_UNKNOWN = 2'd0;
   localparam logic [1:0] VERDICT_VALID   = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;

   typedef struct packed {
      logic       emit;           // byte closes a sentence
      logic [2:0] sentence_type;
      logic [1:0] verdict;
   } nsc_result_type;

   // Checked comma field per kind; zero means no field check.
   function automatic logic [3:0] tok_index(input logic [2:0] k);
      logic [3:0] r;
      unique case (k)
         KIND_GGA: r = 4'd6;
         KIND_GSA: r = 4'd2;
         KIND_GLL: r = 4'd6;
         KIND_RMC: r = 4'd2;
         KIND_VTG: r = 4'd9;
         default:  r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] tok_ref(input logic [2:0] k);
      logic [7:0] r;
      unique case (k)
         KIND_GGA: r = 8'h30;  // '0'
         KIND_GSA: r = 8'h31;  // '1'
         KIND_GLL: r = 8'h41;  // 'A'
         KIND_RMC: r = 8'h41;  // 'A'
         KIND_VTG: r = 8'h4E;  // 'N'
         default:  r = 8'h00;
      endcase
      return r;
   endfunction

   // 1: field must equal the reference; 0: field must differ
   function automatic logic tok_equal(input logic [2:0] k);
      return (k == KIND_GLL) || (k == KIND_RMC);
   endfunction

   // {is_hex, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      priority if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h41 && b <= 8'h46)   r = {1'b1, 4'(b - 8'h37)};
      else if (b >= 8'h61 && b <= 8'h66)   r = {1'b1, 4'(b - 8'h57)};
      else                                 r = 5'd0;
      return r;
   endfunction

   // Kind from characters three to five; bit 3 set on no match.
   function automatic logic [3:0] decide_kind(input logic [7:0] t, input logic [7:0] f,
                                              input logic [7:0] b);
      logic [3:0] r;
      priority if (t == 8'h47 && f == 8'h47 && b == 8'h41) r = {1'b0, KIND_GGA};
      else if (t == 8'h47 && f == 8'h53 && b == 8'h41)   r = {1'b0, KIND_GSA};
      else if (t == 8'h47 && f == 8'h53 && b == 8'h56)   r = {1'b0, KIND_GSV};
      else if (t == 8'h47 && f == 8'h4C && b == 8'h4C)   r = {1'b0, KIND_GLL};
      else if (t == 8'h52 && f == 8'h4D && b == 8'h43)   r = {1'b0, KIND_RMC};
      else if (t == 8'h56 && f == 8'h54 && b == 8'h47)   r = {1'b0, KIND_VTG};
      else if (t == 8'h5A && f == 8'h44 && b == 8'h41)   r = {1'b0, KIND_ZDA};
      else                                               r = {1'b1, KIND_GGA};
      return r;
   endfunction

endpackage

// ----- design/nsc_parser.sv -----
// Per-sentence parse state and the single-pass byte update.
// Depends on nsc_pkg and the classifier assertion macros.
`include "nmea_sentence_classifier_defines.svh"

module nsc_parser
   import nsc_pkg::*;
#(
   parameter int MAX_LEN = NSC_MAX_LEN
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output nsc_result_type res
);

   localparam int PW = $clog2(MAX_LEN);
   localparam logic [PW-1:0] POS_1    = PW'(1);
   localparam logic [PW-1:0] POS_2    = PW'(2);
   localparam logic [PW-1:0] POS_3    = PW'(3);
   localparam logic [PW-1:0] POS_4    = PW'(4);
   localparam logic [PW-1:0] POS_5    = PW'(5);
   localparam logic [PW-1:0] POS_6    = PW'(6);
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_LEN - 1);

   logic          in_sentence_ff,  in_sentence_in;
   logic [PW-1:0] char_position_ff, char_position_in;
   logic [7:0]    third_char_ff,   third_char_in;
   logic [7:0]    fourth_char_ff,  fourth_char_in;
   logic [2:0]    kind_code_ff,    kind_code_in;
   logic          prefix_failed_ff, prefix_failed_in;
   logic [7:0]    running_xor_ff,  running_xor_in;
   logic [4:0]    field_number_ff, field_number_in;
   logic [1:0]    field_count_ff,  field_count_in;
   logic          field_mismatch_ff, field_mismatch_in;
   logic          star_seen_ff,    star_seen_in;
   logic [1:0]    digits_ff,       digits_in;
   logic [7:0]    given_sum_ff,    given_sum_in;

   logic [3:0]    kind_dec;
   logic [4:0]    hex;
   logic [3:0]    chk_index;
   logic          sentence_end;
   logic          ok;
   logic          eq;
   logic          fix_valid;

   always_comb begin
      in_sentence_in    = in_sentence_ff;
      char_position_in  = char_position_ff;
      third_char_in     = third_char_ff;
      fourth_char_in    = fourth_char_ff;
      kind_code_in      = kind_code_ff;
      prefix_failed_in  = prefix_failed_ff;
      running_xor_in    = running_xor_ff;
      field_number_in   = field_number_ff;
      field_count_in    = field_count_ff;
      field_mismatch_in = field_mismatch_ff;
      star_seen_in      = star_seen_ff;
      digits_in         = digits_ff;
      given_sum_in      = given_sum_ff;
      kind_dec          = decide_kind(third_char_ff, fourth_char_ff, rx_byte);
      hex               = hex_value(rx_byte);
      chk_index         = 4'd0;
      sentence_end      = 1'b0;
      ok                = 1'b0;
      eq                = 1'b0;
      fix_valid         = 1'b1;
      res               = '0;

      if (!in_sentence_ff) begin
         if (rx_byte == CH_DOLLAR) begin
            in_sentence_in    = 1'b1;
            char_position_in  = POS_1;
            third_char_in     = '0;
            fourth_char_in    = '0;
            kind_code_in      = KIND_GGA;
            prefix_failed_in  = 1'b0;
            running_xor_in    = '0;
            field_number_in   = '0;
            field_count_in    = '0;
            field_mismatch_in = 1'b0;
            star_seen_in      = 1'b0;
            digits_in         = '0;
            given_sum_in      = '0;
         end
      end else begin
         // prefix "$GP" + three-letter type
         if (char_position_ff == POS_1 && rx_byte != CH_G) prefix_failed_in = 1'b1;
         else if (char_position_ff == POS_2 && rx_byte != CH_P) prefix_failed_in = 1'b1;
         else if (char_position_ff == POS_3) third_char_in = rx_byte;
         else if (char_position_ff == POS_4) fourth_char_in = rx_byte;
         else if (char_position_ff == POS_5) begin
            kind_code_in = kind_dec[2:0];
            if (kind_dec[3]) prefix_failed_in = 1'b1;
         end

         chk_index = tok_index(kind_code_in);

         if (rx_byte != CH_CR && rx_byte != CH_LF) begin
            if (!star_seen_ff) begin
               if (rx_byte == CH_STAR) begin
                  star_seen_in = 1'b1;
               end else begin
                  running_xor_in = running_xor_ff ^ rx_byte;
                  if (rx_byte == CH_COMMA) begin
                     if (field_number_ff != 5'd31) field_number_in = field_number_ff + 5'd1;
                  end else if (char_position_ff >= POS_6 && chk_index != 4'd0 &&
                               field_number_ff == {1'b0, chk_index}) begin
                     if (field_count_ff != 2'd0 || rx_byte != tok_ref(kind_code_in))
                        field_mismatch_in = 1'b1;
                     if (field_count_ff != 2'd2) field_count_in = field_count_ff + 2'd1;
                  end
               end
            end else begin
               if (digits_ff < 2'd2 && hex[4]) begin
                  given_sum_in = {given_sum_ff[3:0], hex[3:0]};
                  digits_in    = digits_ff + 2'd1;
               end else begin
                  digits_in = 2'd3;  // malformed checksum
               end
            end
         end

         char_position_in = char_position_ff + POS_1;
         sentence_end     = (rx_byte == CH_LF) || (char_position_in == POS_LAST);

         ok = (char_position_in >= POS_6) && !prefix_failed_in;
         if (star_seen_in && (digits_in != 2'd2 || given_sum_in != running_xor_in))
            ok = 1'b0;

         eq = (field_count_in != 2'd0) && !field_mismatch_in;
         if (chk_index != 4'd0) fix_valid = tok_equal(kind_code_in) ? eq : !eq;

         if (sentence_end) begin
            res.emit          = 1'b1;
            res.sentence_type = ok ? kind_code_in : KIND_GGA;
            res.verdict       = !ok ? VERDICT_UNKNOWN :
                                (fix_valid ? VERDICT_VALID : VERDICT_INVALID);
            in_sentence_in    = 1'b0;
            char_position_in  = '0;
            third_char_in     = '0;
            fourth_char_in    = '0;
            kind_code_in      = KIND_GGA;
            prefix_failed_in  = 1'b0;
            running_xor_in    = '0;
            field_number_in   = '0;
            field_count_in    = '0;
            field_mismatch_in = 1'b0;
            star_seen_in      = 1'b0;
            digits_in         = '0;
            given_sum_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff    <= 1'b0;
         char_position_ff  <= '0;
         third_char_ff     <= '0;
         fourth_char_ff    <= '0;
         kind_code_ff      <= KIND_GGA;
         prefix_failed_ff  <= 1'b0;
         running_xor_ff    <= '0;
         field_number_ff   <= '0;
         field_count_ff    <= '0;
         field_mismatch_ff <= 1'b0;
         star_seen_ff      <= 1'b0;
         digits_ff         <= '0;
         given_sum_ff      <= '0;
      end else if (step) begin
         in_sentence_ff    <= in_sentence_in;
         char_position_ff  <= char_position_in;
         third_char_ff     <= third_char_in;
         fourth_char_ff    <= fourth_char_in;
         kind_code_ff      <= kind_code_in;
         prefix_failed_ff  <= prefix_failed_in;
         running_xor_ff    <= running_xor_in;
         field_number_ff   <= field_number_in;
         field_count_ff    <= field_count_in;
         field_mismatch_ff <= field_mismatch_in;
         star_seen_ff      <= star_seen_in;
         digits_ff         <= digits_in;
         given_sum_ff      <= given_sum_in;
      end
   end

   `NSC_ASSERT_NEXT(a_idle_after_end, clock, reset, step && res.emit, !in_sentence_ff, "no idle")
   `NSC_ASSERT_NOW(a_pos_nonzero, clock, reset, in_sentence_ff, char_position_ff != '0, "pos zero")

endmodule

// ----- design/nmea_sentence_classifier.sv -----
// The request holding the closing byte is registered in the input register, and its result in
// the result register. Throughput: one byte per cycle, set by the single-pass parser update;
// a result waiting on rsp_ready stalls only a closing byte.
// Reset (synchronous, active high) empties both registers and drops any partial sentence.
// Top level of the NMEA sentence classifier; depends on nsc_pkg and nsc_parser.
`include "nmea_sentence_classifier_defines.svh"

module nmea_sentence_classifier
   import nsc_pkg::*;
#(
   parameter int MAX_LEN = NSC_MAX_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_sentence_type,
   output logic [1:0] rsp_verdict
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_type_ff;
   logic [1:0] rsp_verdict_ff;

   nsc_result_type parse_res;
   logic           advance;

   nsc_parser #(
      .MAX_LEN (MAX_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .res     (parse_res)
   );

   // A byte moves through the parser unless it closes a sentence while the
   // previous result is still held.
   assign advance   = in_valid_ff && (!parse_res.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_valid && req_ready) in_valid_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (advance && parse_res.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (advance && parse_res.emit) begin
         rsp_type_ff    <= parse_res.sentence_type;
         rsp_verdict_ff <= parse_res.verdict;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sentence_type = rsp_type_ff;
   assign rsp_verdict       = rsp_verdict_ff;

   `NSC_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready && parse_res.emit, !advance, "held result would be overwritten")
   `NSC_ASSERT_NOW(a_unknown_type, clock, reset, rsp_valid_ff && rsp_verdict_ff == VERDICT_UNKNOWN, rsp_type_ff == KIND_GGA, "unknown verdict with nonzero type")

endmodule
